### design/lcdnw_pkg.sv
// ----------------------------------------------------------------------------
// lcdnw_pkg
// Shared types and constants for the character LCD nibble writer.
// ----------------------------------------------------------------------------
package lcdnw_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Reset values of the configuration registers and the position cache
    localparam logic [7:0] RST_LINE_TWO_START = 8'd8;
    localparam logic [7:0] RST_LINE_ONE_CMD   = 8'd128;
    localparam logic [7:0] RST_LINE_TWO_CMD   = 8'd192;
    localparam logic [7:0] RST_EXP_POSITION   = 8'hFF;

    // Hold times in delay units for the enable-low steps
    localparam logic [5:0] HOLD_NONE       = 6'd0;
    localparam logic [5:0] HOLD_CMD_UPPER  = 6'd1;
    localparam logic [5:0] HOLD_CMD_LOWER  = 6'd41;
    localparam logic [5:0] HOLD_DATA_UPPER = 6'd0;
    localparam logic [5:0] HOLD_DATA_LOWER = 6'd1;

    typedef enum logic [1:0] {
        CFG_LINE_TWO_START = 2'd0,
        CFG_LINE_ONE_CMD   = 2'd1,
        CFG_LINE_TWO_CMD   = 2'd2
    } cfg_idx_t;

    // One classified request: optional address command, then one byte
    typedef struct packed {
        logic       addr_en;
        logic [7:0] addr_cmd;
        logic       data_rs;
        logic [7:0] data_byte;
    } lcdnw_job_t;

endpackage

### design/char_lcd_nibble_writer_core.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_core
// Character LCD 4-bit bus writer: requests in, pin-step beats out.
// ----------------------------------------------------------------------------
// Each request yields 4 output beats (raw command, or a character whose
// position matches the cached next position) or 8 beats (character that
// needs a set-address command first). The step generator emits one beat per
// cycle while the output is not stalled, and the next job starts once the
// final beat of the current one is loaded. The job in progress stays at the
// head of a two-entry job queue until its final beat is loaded, so the input
// side can accept one more request ahead while beats drain.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_core
    import lcdnw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // byte_value[7:0], position[7:0]
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // enable_pin, data_nibble[3:0], hold_units[5:0], pad
    output logic        m_axis_tuser,   // reg_select
    output logic        m_axis_tlast    // last_step
);

    lcdnw_job_t new_job;
    lcdnw_job_t head_job;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;
    logic       in_accept;

    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    lcdnw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (in_accept),
        .req_type   (s_axis_tuser),
        .byte_value (s_axis_tdata[7:0]),
        .position   (s_axis_tdata[15:8]),
        .job        (new_job)
    );

    lcdnw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_accept),
        .push_job (new_job),
        .pop      (q_pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    lcdnw_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_job      (head_job),
        .head_valid    (!q_empty),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job retired from empty queue");

    a_full_empty_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && q_empty))
        else $error("queue both full and empty");

    a_last_enable_low: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[0] == 1'b0))
        else $error("final step with enable high");

    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (m_axis_tvalid && m_axis_tlast))
        else $error("job retired without a final beat");
`endif

endmodule

### design/lcdnw_front.sv
// ----------------------------------------------------------------------------
// lcdnw_front
// Accepts requests, keeps the position cache and builds the address command.
// ----------------------------------------------------------------------------
module lcdnw_front
    import lcdnw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       accept,
    input  logic       req_type,
    input  logic [7:0] byte_value,
    input  logic [7:0] position,
    output lcdnw_job_t job
);

    logic [7:0] line_two_start_reg, line_two_start_next;
    logic [7:0] line_one_cmd_reg, line_one_cmd_next;
    logic [7:0] line_two_cmd_reg, line_two_cmd_next;
    logic [7:0] exp_pos_reg, exp_pos_next;
    logic       on_line_two;
    logic [7:0] addr_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_two_start_reg <= RST_LINE_TWO_START;
            line_one_cmd_reg   <= RST_LINE_ONE_CMD;
            line_two_cmd_reg   <= RST_LINE_TWO_CMD;
            exp_pos_reg        <= RST_EXP_POSITION;
        end
        else
        begin
            line_two_start_reg <= line_two_start_next;
            line_one_cmd_reg   <= line_one_cmd_next;
            line_two_cmd_reg   <= line_two_cmd_next;
            exp_pos_reg        <= exp_pos_next;
        end
    end

    always_comb
    begin
        line_two_start_next = line_two_start_reg;
        line_one_cmd_next   = line_one_cmd_reg;
        line_two_cmd_next   = line_two_cmd_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_LINE_TWO_START: line_two_start_next = cfg_data;
                CFG_LINE_ONE_CMD:   line_one_cmd_next   = cfg_data;
                CFG_LINE_TWO_CMD:   line_two_cmd_next   = cfg_data;
                default:            ;
            endcase
        end
    end

    assign on_line_two = (position >= line_two_start_reg);
    assign addr_cmd    = on_line_two ? (line_two_cmd_reg + position - line_two_start_reg)
                                     : (line_one_cmd_reg + position);

    // a character always leaves the cache one past its own position
    assign exp_pos_next = (accept && !req_type) ? (position + 8'd1) : exp_pos_reg;

    always_comb
    begin
        job.addr_en   = !req_type && (exp_pos_reg != position);
        job.addr_cmd  = addr_cmd;
        job.data_rs   = !req_type;
        job.data_byte = byte_value;
    end

endmodule

### design/lcdnw_queue.sv
// ----------------------------------------------------------------------------
// lcdnw_queue
// Short job queue between the front and the step generator.
// ----------------------------------------------------------------------------
module lcdnw_queue
    import lcdnw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  lcdnw_job_t push_job,
    input  logic       pop,
    output lcdnw_job_t head_job,
    output logic       full,
    output logic       empty
);

    lcdnw_job_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    assign head_job = mem_reg[rd_ptr_reg];
    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);

endmodule

### design/lcdnw_back.sv
// ----------------------------------------------------------------------------
// lcdnw_back
// Step generator: turns one job into four or eight pin-step beats.
// ----------------------------------------------------------------------------
module lcdnw_back
    import lcdnw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  lcdnw_job_t  head_job,
    input  logic        head_valid,
    output logic        pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // enable_pin, data_nibble[3:0], hold_units[5:0], pad
    output logic        m_axis_tuser,   // reg_select
    output logic        m_axis_tlast    // last_step
);

    logic [2:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_rs_reg, out_rs_next;
    logic       out_en_reg, out_en_next;
    logic [3:0] out_nib_reg, out_nib_next;
    logic [5:0] out_hold_reg, out_hold_next;
    logic       out_last_reg, out_last_next;

    logic       advance;
    logic       in_addr;
    logic [1:0] sub;
    logic [7:0] cur_byte;
    logic       cur_rs;
    logic       cur_last;
    logic [5:0] cur_hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rs_reg   <= out_rs_next;
        out_en_reg   <= out_en_next;
        out_nib_reg  <= out_nib_next;
        out_hold_reg <= out_hold_next;
        out_last_reg <= out_last_next;
    end

    assign advance  = !out_valid_reg || m_axis_tready;
    assign sub      = step_reg[1:0];
    assign in_addr  = head_job.addr_en && !step_reg[2];
    assign cur_byte = in_addr ? head_job.addr_cmd : head_job.data_byte;
    assign cur_rs   = in_addr ? 1'b0 : head_job.data_rs;
    assign cur_last = (sub == 2'd3) && !in_addr;

    always_comb
    begin
        case (sub)
            2'd1:    cur_hold = cur_rs ? HOLD_DATA_UPPER : HOLD_CMD_UPPER;
            2'd3:    cur_hold = cur_rs ? HOLD_DATA_LOWER : HOLD_CMD_LOWER;
            default: cur_hold = HOLD_NONE;
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_rs_next    = out_rs_reg;
        out_en_next    = out_en_reg;
        out_nib_next   = out_nib_reg;
        out_hold_next  = out_hold_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        if (advance)
        begin
            out_valid_next = head_valid;
            if (head_valid)
            begin
                out_rs_next   = cur_rs;
                out_en_next   = !sub[0];
                out_nib_next  = sub[1] ? cur_byte[3:0] : cur_byte[7:4];
                out_hold_next = cur_hold;
                out_last_next = cur_last;
                // retire the job on its final step
                pop           = cur_last;
                step_next     = cur_last ? 3'd0 : step_reg + 3'd1;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_hold_reg, out_nib_reg, out_en_reg};
    assign m_axis_tuser  = out_rs_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
